FILE: rtl/rtccal_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and decode helpers for the RTC snapshot converter.
// No dependencies; imported by rtc_raw_to_calendar_and_epoch.
package rtccal_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_BCD_MODE    = 2'd0;
   localparam logic [1:0] CSR_TWELVE_HOUR = 2'd1;
   localparam logic [1:0] CSR_CENTURY     = 2'd2;

   localparam int unsigned PM_BIT          = 7;
   localparam logic [7:0]  DEFAULT_CENTURY = 8'd20;
   localparam logic [14:0] YEAR_MIN        = 15'd1970;
   localparam logic [14:0] YEAR_MAX        = 15'd2099;
   localparam logic [14:0] CENTURY_SCALE   = 15'd100;
   localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN    = 17'd60;
   localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
   localparam logic [41:0] MS_PER_SEC      = 42'd1000;
   localparam logic [15:0] DAYS_PER_YEAR   = 16'd365;
   // 1970-01-01 was a Thursday: (days + 4) mod 7 gives 0 for Sunday
   localparam logic [15:0] EPOCH_WD_OFS    = 16'd4;
   // floor(x / 7) = (x * ceil(2^20 / 7)) >> 20, exact for x below 2^18
   localparam logic [33:0] WEEK_RECIP      = 34'd149797;
   localparam int unsigned WEEK_SHIFT      = 20;

   // Calendar fields carried down the back end of the pipe
   typedef struct packed {
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hr;
      logic [4:0]  day;
      logic [3:0]  mon;
      logic [11:0] year;
   } cal_fields_type;

   function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bcd);
      logic [7:0] hi_x10;
      hi_x10 = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
      // hi * 10 = hi * 8 + hi * 2; nibble digits above 9 pass through
      if (bcd) begin
         return hi_x10 + {4'h0, b[3:0]};
      end
      return b;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] mon);
      logic [4:0] len;
      unique case (mon)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] month_start(input logic [3:0] mon);
      logic [8:0] ofs;
      unique case (mon)
         4'd2:    ofs = 9'd31;
         4'd3:    ofs = 9'd59;
         4'd4:    ofs = 9'd90;
         4'd5:    ofs = 9'd120;
         4'd6:    ofs = 9'd151;
         4'd7:    ofs = 9'd181;
         4'd8:    ofs = 9'd212;
         4'd9:    ofs = 9'd243;
         4'd10:   ofs = 9'd273;
         4'd11:   ofs = 9'd304;
         4'd12:   ofs = 9'd334;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

FILE: rtl/rtc_raw_to_calendar_and_epoch.sv
`timescale 1ns / 1ps
// RTC register snapshot to binary calendar fields, weekday and Unix milliseconds.
// Depends on rtccal_pkg.
//
// One snapshot can be started every clock cycle while busy is low; its result word appears
// on the rsp_ ports with rsp_strobe once it leaves the last stage, for one cycle only, and the
// receiver cannot stall it. The pipeline stages are byte decode, year build, month and
// time-of-day sums, day count, the two constant multiplies for seconds and weekday, and the
// final multiply to milliseconds. busy is high only while reset is held. Results for a bad
// snapshot carry invalid set and every other field zero. Configuration writes take effect
// at the next edge and should only be made with no words in flight.
module rtc_raw_to_calendar_and_epoch (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_raw_seconds,
   input  logic [7:0]  req_raw_minutes,
   input  logic [7:0]  req_raw_hours,
   input  logic [7:0]  req_raw_day,
   input  logic [7:0]  req_raw_month,
   input  logic [7:0]  req_raw_year,
   input  logic [7:0]  req_raw_century,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_seconds,
   output logic [5:0]  rsp_minutes,
   output logic [4:0]  rsp_hours,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [11:0] rsp_full_year,
   output logic [2:0]  rsp_weekday,
   output logic [41:0] rsp_epoch_millis,
   output logic        rsp_invalid,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [0:0]  csr_wdata
);
   import rtccal_pkg::*;

   // configuration
   logic bcd_mode_ff, twelve_hour_ff, century_ff;

   // stage 1: decoded bytes
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_bad_ff, s1_bad_in;
   logic [5:0] s1_sec_ff, s1_sec_in;
   logic [5:0] s1_min_ff, s1_min_in;
   logic [4:0] s1_hr_ff, s1_hr_in;
   logic [7:0] s1_day_ff, s1_day_in;
   logic [3:0] s1_mon_ff, s1_mon_in;
   logic [6:0] s1_yr2_ff, s1_yr2_in;
   logic [7:0] s1_cen_ff, s1_cen_in;

   // stage 2: full year
   logic        s2_valid_ff, s2_bad_ff, s2_bad_in;
   logic [5:0]  s2_sec_ff, s2_min_ff;
   logic [4:0]  s2_hr_ff;
   logic [7:0]  s2_day_ff;
   logic [3:0]  s2_mon_ff;
   logic [11:0] s2_year_ff, s2_year_in;
   logic [7:0]  s2_yoff_ff, s2_yoff_in;
   logic        s2_leap_ff, s2_leap_in;

   // stage 3: day check and partial sums
   logic           s3_valid_ff, s3_bad_ff, s3_bad_in;
   cal_fields_type s3_cal_ff, s3_cal_in;
   logic [15:0]    s3_ydays_ff, s3_ydays_in;
   logic [8:0]     s3_moff_ff, s3_moff_in;
   logic [16:0]    s3_sod_ff, s3_sod_in;

   // stage 4: day count
   logic           s4_valid_ff, s4_bad_ff;
   cal_fields_type s4_cal_ff;
   logic [15:0]    s4_days_ff, s4_days_in;
   logic [16:0]    s4_sod_ff;

   // stage 5: seconds and weekday quotient
   logic           s5_valid_ff, s5_bad_ff;
   cal_fields_type s5_cal_ff;
   logic [31:0]    s5_secs_ff, s5_secs_in;
   logic [15:0]    s5_wx_ff, s5_wx_in;
   logic [13:0]    s5_wq_ff, s5_wq_in;
   logic [33:0]    wq_prod;

   // stage 6: output word
   logic [41:0]    millis_in;
   logic [15:0]    wrem;
   logic [2:0]     weekday_in;

   assign busy = reset;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_mode_ff    <= 1'b1;
         twelve_hour_ff <= 1'b0;
         century_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BCD_MODE:    bcd_mode_ff    <= csr_wdata[0];
            CSR_TWELVE_HOUR: twelve_hour_ff <= csr_wdata[0];
            CSR_CENTURY:     century_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage 1
   always_comb begin
      logic [7:0] sec, min, mon, yr2, hr;
      logic       hr_bad;
      sec = bcd_decode(req_raw_seconds, bcd_mode_ff);
      min = bcd_decode(req_raw_minutes, bcd_mode_ff);
      mon = bcd_decode(req_raw_month, bcd_mode_ff);
      yr2 = bcd_decode(req_raw_year, bcd_mode_ff);
      if (twelve_hour_ff) begin
         // strip PM first, decode, then fold 12 AM to 0 and add 12 for PM
         hr     = bcd_decode({1'b0, req_raw_hours[6:0]}, bcd_mode_ff);
         hr_bad = (hr < 8'd1) || (hr > 8'd12);
         if (hr == 8'd12) begin
            hr = 8'd0;
         end
         if (req_raw_hours[PM_BIT]) begin
            hr = hr + 8'd12;
         end
      end else begin
         hr     = bcd_decode(req_raw_hours, bcd_mode_ff);
         hr_bad = hr > 8'd23;
      end
      s1_valid_in = start && !busy;
      s1_bad_in   = hr_bad || (sec > 8'd59) || (min > 8'd59) || (mon < 8'd1)
                    || (mon > 8'd12) || (yr2 > 8'd99);
      s1_sec_in   = sec[5:0];
      s1_min_in   = min[5:0];
      s1_hr_in    = hr[4:0];
      s1_day_in   = bcd_decode(req_raw_day, bcd_mode_ff);
      s1_mon_in   = mon[3:0];
      s1_yr2_in   = yr2[6:0];
      s1_cen_in   = century_ff ? bcd_decode(req_raw_century, bcd_mode_ff)
                               : DEFAULT_CENTURY;
   end

   // stage 2
   always_comb begin
      logic [14:0] year;
      year       = 15'(s1_cen_ff) * CENTURY_SCALE + 15'(s1_yr2_ff);
      s2_bad_in  = s1_bad_ff || (year < YEAR_MIN) || (year > YEAR_MAX);
      s2_year_in = year[11:0];
      // offset runs to 129, so eight bits
      s2_yoff_in = 8'(year - YEAR_MIN);
      // 2000 is the only century year in range and it is a leap year
      s2_leap_in = year[1:0] == 2'b00;
   end

   // stage 3
   always_comb begin
      logic [4:0] len;
      len = (s2_mon_ff == 4'd2 && s2_leap_ff) ? 5'd29 : month_length(s2_mon_ff);
      s3_bad_in = s2_bad_ff || (s2_day_ff < 8'd1) || (s2_day_ff > 8'(len));
      s3_cal_in.sec  = s2_sec_ff;
      s3_cal_in.min  = s2_min_ff;
      s3_cal_in.hr   = s2_hr_ff;
      s3_cal_in.day  = s2_day_ff[4:0];
      s3_cal_in.mon  = s2_mon_ff;
      s3_cal_in.year = s2_year_ff;
      // leap days in 1970..year-1 reduce to (yoff + 1) / 4 over this range
      s3_ydays_in = 16'(s2_yoff_ff) * DAYS_PER_YEAR + 16'((s2_yoff_ff + 8'd1) >> 2);
      s3_moff_in  = month_start(s2_mon_ff)
                    + 9'((s2_mon_ff > 4'd2) && s2_leap_ff);
      s3_sod_in   = 17'(s2_hr_ff) * SECS_PER_HOUR + 17'(s2_min_ff) * SECS_PER_MIN
                    + 17'(s2_sec_ff);
   end

   // stage 4
   assign s4_days_in = s3_ydays_ff + 16'(s3_moff_ff) + 16'(s3_cal_ff.day) - 16'd1;

   // stage 5
   assign s5_secs_in = 32'(s4_days_ff) * SECS_PER_DAY + 32'(s4_sod_ff);
   assign s5_wx_in   = s4_days_ff + EPOCH_WD_OFS;
   assign wq_prod    = 34'(s5_wx_in) * WEEK_RECIP;
   assign s5_wq_in   = wq_prod[WEEK_SHIFT +: 14];

   // stage 6
   assign millis_in  = 42'(s5_secs_ff) * MS_PER_SEC;
   assign wrem       = s5_wx_ff - ({2'b00, s5_wq_ff} << 3) + {2'b00, s5_wq_ff};
   assign weekday_in = wrem[2:0] + 3'd1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         rsp_strobe  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         rsp_strobe  <= s5_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_bad_ff  <= s1_bad_in;
      s1_sec_ff  <= s1_sec_in;
      s1_min_ff  <= s1_min_in;
      s1_hr_ff   <= s1_hr_in;
      s1_day_ff  <= s1_day_in;
      s1_mon_ff  <= s1_mon_in;
      s1_yr2_ff  <= s1_yr2_in;
      s1_cen_ff  <= s1_cen_in;

      s2_bad_ff  <= s2_bad_in;
      s2_sec_ff  <= s1_sec_ff;
      s2_min_ff  <= s1_min_ff;
      s2_hr_ff   <= s1_hr_ff;
      s2_day_ff  <= s1_day_ff;
      s2_mon_ff  <= s1_mon_ff;
      s2_year_ff <= s2_year_in;
      s2_yoff_ff <= s2_yoff_in;
      s2_leap_ff <= s2_leap_in;

      s3_bad_ff   <= s3_bad_in;
      s3_cal_ff   <= s3_cal_in;
      s3_ydays_ff <= s3_ydays_in;
      s3_moff_ff  <= s3_moff_in;
      s3_sod_ff   <= s3_sod_in;

      s4_bad_ff  <= s3_bad_ff;
      s4_cal_ff  <= s3_cal_ff;
      s4_days_ff <= s4_days_in;
      s4_sod_ff  <= s3_sod_ff;

      s5_bad_ff  <= s4_bad_ff;
      s5_cal_ff  <= s4_cal_ff;
      s5_secs_ff <= s5_secs_in;
      s5_wx_ff   <= s5_wx_in;
      s5_wq_ff   <= s5_wq_in;

      // a bad snapshot reports zero in every field but invalid
      rsp_invalid      <= s5_bad_ff;
      rsp_seconds      <= s5_bad_ff ? 6'd0  : s5_cal_ff.sec;
      rsp_minutes      <= s5_bad_ff ? 6'd0  : s5_cal_ff.min;
      rsp_hours        <= s5_bad_ff ? 5'd0  : s5_cal_ff.hr;
      rsp_day_of_month <= s5_bad_ff ? 5'd0  : s5_cal_ff.day;
      rsp_month_number <= s5_bad_ff ? 4'd0  : s5_cal_ff.mon;
      rsp_full_year    <= s5_bad_ff ? 12'd0 : s5_cal_ff.year;
      rsp_weekday      <= s5_bad_ff ? 3'd0  : weekday_in;
      rsp_epoch_millis <= s5_bad_ff ? 42'd0 : millis_in;
   end

   // every started snapshot yields exactly one word once it leaves the last stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_strobe)
      else $error("started snapshot produced no result word");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 6))
      else $error("result word without a matching start");

   a_valid_ranges: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_invalid) |-> (rsp_full_year >= 12'd1970 && rsp_full_year <= 12'd2099
         && rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12
         && rsp_hours <= 5'd23 && rsp_weekday != 3'd0 && rsp_day_of_month != 5'd0))
      else $error("valid word carries a field out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_invalid) |-> (rsp_epoch_millis == 42'd0 && rsp_weekday == 3'd0
         && rsp_full_year == 12'd0 && rsp_month_number == 4'd0))
      else $error("invalid word carries non-zero fields");

endmodule
